>>> rtl/hsvrgb_pkg.sv
package hsvrgb_pkg;

  typedef struct packed {
    logic [8:0] hue;
    logic [6:0] saturation;
    logic [6:0] brightness;
  } hsvrgb_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } hsvrgb_out_t;

  // three color lanes, indexed by the CH_* constants
  typedef logic [2:0][7:0] hsvrgb_rgb_t;

  localparam int CH_RED   = 2;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 0;

  localparam logic [7:0] CHAN_FULL = 8'd255;
  localparam logic [6:0] PCT_MAX   = 7'd100;

  // floor(x / 100) for x <= 25500: reciprocal 5243 / 2^19 is exact in that range
  localparam logic [27:0] DIV100_MUL   = 28'd5243;
  localparam int          DIV100_SHIFT = 19;

  function automatic logic [7:0] div100(input logic [14:0] x);
    logic [27:0] p;
    p = {13'd0, x} * DIV100_MUL;
    return p[DIV100_SHIFT+7:DIV100_SHIFT];
  endfunction

  function automatic logic [6:0] clamp_pct(input logic [6:0] x);
    return (x > PCT_MAX) ? PCT_MAX : x;
  endfunction

endpackage

>>> rtl/hsv_to_rgb_percent_unit.sv
// An accepted item passes five register stages (s1 to s4, then the output register) before out_valid rises.
// Throughput: one item per cycle while out_stall is low; five register stages, each one multiply or less.
// A stall at the output backs up stage by stage; empty stages still fill.
// Reset (rst_n low, synchronous) clears all stage valid bits; payload is not reset.
module hsv_to_rgb_percent_unit import hsvrgb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  hsvrgb_in_t  in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output hsvrgb_out_t out_data
);

  hsvrgb_rgb_t base;

  logic        adv1, adv2, adv3, adv4, adv5;

  logic        s1_vld_r;
  hsvrgb_rgb_t s1_rgb_r;
  logic [6:0]  s1_inv_r;
  logic [6:0]  s1_bri_r;

  logic        s2_vld_r;
  hsvrgb_rgb_t s2_rgb_r;
  logic [2:0][14:0] s2_prod_r;
  logic [6:0]  s2_bri_r;

  logic        s3_vld_r;
  hsvrgb_rgb_t s3_rgb_r;
  logic [6:0]  s3_bri_r;

  logic        s4_vld_r;
  logic [2:0][14:0] s4_prod_r;

  logic        out_valid_r;
  hsvrgb_out_t out_data_r;

  hsvrgb_rgb_t s1_rgb_nxt;
  logic [2:0][14:0] s2_prod_nxt;
  hsvrgb_rgb_t s3_rgb_nxt;
  logic [2:0][14:0] s4_prod_nxt;
  hsvrgb_out_t out_data_nxt;
  logic [8:0]  sum9;

  hsvrgb_sector u_sector (
    .hue  (in_data.hue),
    .base (base)
  );

  // a stage moves when it is empty or its successor moves
  assign adv5 = !out_valid_r || !out_stall;
  assign adv4 = !s4_vld_r || adv5;
  assign adv3 = !s3_vld_r || adv4;
  assign adv2 = !s2_vld_r || adv3;
  assign adv1 = !s1_vld_r || adv2;
  assign in_stall = !adv1;

  assign s1_rgb_nxt = base;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s2_prod_nxt[i] = 15'((CHAN_FULL - s1_rgb_r[i]) * s1_inv_r);
    end
  end

  always_comb begin
    sum9 = '0;
    for (int i = 0; i < 3; i++) begin
      sum9 = {1'b0, s2_rgb_r[i]} + {1'b0, div100(s2_prod_r[i])};
      s3_rgb_nxt[i] = sum9[7:0];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s4_prod_nxt[i] = 15'(s3_rgb_r[i] * s3_bri_r);
    end
  end

  always_comb begin
    out_data_nxt.red   = div100(s4_prod_r[CH_RED]);
    out_data_nxt.green = div100(s4_prod_r[CH_GREEN]);
    out_data_nxt.blue  = div100(s4_prod_r[CH_BLUE]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      s4_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv1) s1_vld_r    <= in_valid;
      if (adv2) s2_vld_r    <= s1_vld_r;
      if (adv3) s3_vld_r    <= s2_vld_r;
      if (adv4) s4_vld_r    <= s3_vld_r;
      if (adv5) out_valid_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      s1_rgb_r <= s1_rgb_nxt;
      s1_inv_r <= PCT_MAX - clamp_pct(in_data.saturation);
      s1_bri_r <= clamp_pct(in_data.brightness);
    end
    if (adv2 && s1_vld_r) begin
      s2_rgb_r  <= s1_rgb_r;
      s2_prod_r <= s2_prod_nxt;
      s2_bri_r  <= s1_bri_r;
    end
    if (adv3 && s2_vld_r) begin
      s3_rgb_r <= s3_rgb_nxt;
      s3_bri_r <= s2_bri_r;
    end
    if (adv4 && s3_vld_r) begin
      s4_prod_r <= s4_prod_nxt;
    end
    if (adv5 && s4_vld_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  // input only stalls when every stage holds an item
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_vld_r && s2_vld_r && s3_vld_r && s4_vld_r && out_valid_r))
    else $error("input stalled with a bubble in the pipeline");

  // every hue sector has one channel at full and one at zero
  a_sector_shape: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r |->
      (s1_rgb_r[CH_RED] == CHAN_FULL || s1_rgb_r[CH_GREEN] == CHAN_FULL ||
       s1_rgb_r[CH_BLUE] == CHAN_FULL) &&
      (s1_rgb_r[CH_RED] == 8'd0 || s1_rgb_r[CH_GREEN] == 8'd0 ||
       s1_rgb_r[CH_BLUE] == 8'd0))
    else $error("stage 1 color lacks a full or zero channel");

  // clamped brightness and inverted saturation never exceed 100 percent
  a_bri_range: assert property (@(posedge clk) disable iff (!rst_n)
    s3_vld_r |-> (s3_bri_r <= PCT_MAX && s1_inv_r <= PCT_MAX))
    else $error("percent value out of range");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !s1_vld_r && !s4_vld_r))
    else $error("pipeline not empty after reset");
`endif

endmodule

>>> rtl/hsvrgb_sector.sv
module hsvrgb_sector import hsvrgb_pkg::*; (
  input  logic [8:0]  hue,
  output hsvrgb_rgb_t base
);

  localparam logic [8:0] HUE_WRAP = 9'd360;
  localparam logic [8:0] S1_LO = 9'd61;
  localparam logic [8:0] S2_LO = 9'd121;
  localparam logic [8:0] S3_LO = 9'd181;
  localparam logic [8:0] S4_LO = 9'd241;
  localparam logic [8:0] S5_LO = 9'd301;
  localparam logic [8:0] S1_ORG = 9'd60;
  localparam logic [8:0] S2_ORG = 9'd120;
  localparam logic [8:0] S3_ORG = 9'd180;
  localparam logic [8:0] S4_ORG = 9'd240;
  localparam logic [8:0] S5_ORG = 9'd300;

  logic [8:0] h;
  logic [8:0] ofs;
  logic [5:0] ofs6;
  logic [9:0] ramp17;
  logic [7:0] ramp;

  // hues past the circle wrap once
  assign h = (hue >= HUE_WRAP) ? (hue - HUE_WRAP) : hue;

  always_comb begin
    if (h < S1_LO) begin
      ofs = h;
    end else if (h < S2_LO) begin
      ofs = h - S1_ORG;
    end else if (h < S3_LO) begin
      ofs = h - S2_ORG;
    end else if (h < S4_LO) begin
      ofs = h - S3_ORG;
    end else if (h < S5_LO) begin
      ofs = h - S4_ORG;
    end else begin
      ofs = h - S5_ORG;
    end
  end

  // 425/100 == 17/4, offset is at most 60
  assign ofs6   = ofs[5:0];
  assign ramp17 = {ofs6, 4'd0} + {4'd0, ofs6};
  assign ramp   = ramp17[9:2];

  always_comb begin
    base = '0;
    if (h < S1_LO) begin
      base[CH_RED]   = CHAN_FULL;
      base[CH_GREEN] = ramp;
    end else if (h < S2_LO) begin
      base[CH_RED]   = CHAN_FULL - ramp;
      base[CH_GREEN] = CHAN_FULL;
    end else if (h < S3_LO) begin
      base[CH_GREEN] = CHAN_FULL;
      base[CH_BLUE]  = ramp;
    end else if (h < S4_LO) begin
      base[CH_GREEN] = CHAN_FULL - ramp;
      base[CH_BLUE]  = CHAN_FULL;
    end else if (h < S5_LO) begin
      base[CH_RED]   = ramp;
      base[CH_BLUE]  = CHAN_FULL;
    end else begin
      base[CH_RED]   = CHAN_FULL;
      base[CH_BLUE]  = CHAN_FULL - ramp;
    end
  end

endmodule
